[design/alu_cf_pkg.sv]
package alu_cf_pkg;

    localparam int DATA_W  = 64;
    localparam int OP_W    = 4;
    localparam int SHAMT_W = 6;
    localparam int COND_W  = 4;
    localparam int FLAG_W  = 4;

    localparam int FLAG_N = 3;
    localparam int FLAG_Z = 2;
    localparam int FLAG_C = 1;
    localparam int FLAG_V = 0;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 4'd0,
        OP_SUB    = 4'd1,
        OP_NOT    = 4'd2,
        OP_OR     = 4'd3,
        OP_XOR    = 4'd4,
        OP_AND    = 4'd5,
        OP_MOVK   = 4'd6,
        OP_LSL    = 4'd7,
        OP_LSR    = 4'd8,
        OP_ASR    = 4'd9,
        OP_PASS_A = 4'd10,
        OP_PASS_B = 4'd11
    } op_t;

    typedef enum logic [COND_W-1:0] {
        COND_EQ = 4'd0,
        COND_NE = 4'd1,
        COND_CS = 4'd2,
        COND_CC = 4'd3,
        COND_MI = 4'd4,
        COND_PL = 4'd5,
        COND_VS = 4'd6,
        COND_VC = 4'd7,
        COND_HI = 4'd8,
        COND_LS = 4'd9,
        COND_GE = 4'd10,
        COND_LT = 4'd11,
        COND_GT = 4'd12,
        COND_LE = 4'd13,
        COND_AL = 4'd14,
        COND_NV = 4'd15
    } cond_t;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [DATA_W-1:0]  operand_a;
        logic [DATA_W-1:0]  operand_b;
        logic [SHAMT_W-1:0] move_shift;
        logic               set_flags;
        logic [COND_W-1:0]  condition;
    } req_beat_t;

    typedef struct packed {
        logic              flag_we;
        logic [FLAG_W-1:0] nzcv;
    } flag_upd_t;

endpackage

[design/alu_cf_if.sv]
interface alu_cf_req_if;
    import alu_cf_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [DATA_W-1:0]  operand_a;
    logic [DATA_W-1:0]  operand_b;
    logic [SHAMT_W-1:0] move_shift;
    logic               set_flags;
    logic [COND_W-1:0]  condition;

    modport source
    (
        output valid, op, operand_a, operand_b, move_shift, set_flags, condition,
        input  ready
    );

    modport sink
    (
        input  valid, op, operand_a, operand_b, move_shift, set_flags, condition,
        output ready
    );
endinterface

interface alu_cf_rsp_if;
    import alu_cf_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] result;
    logic              cond_true;
    logic [FLAG_W-1:0] flags_out;

    modport source
    (
        output valid, result, cond_true, flags_out,
        input  ready
    );

    modport sink
    (
        input  valid, result, cond_true, flags_out,
        output ready
    );
endinterface

[design/alu_with_condition_flags_core.sv]
// 64-bit ALU with a stored NZCV flag register. One beat is taken every cycle
// while the result register is not stalled: the beat is captured in an input
// register, passes through one 64-bit adder or barrel shifter, and lands in the
// result register. The flags are written as a beat leaves the input register,
// so the following beat already tests and reports them. While the result
// register is stalled the input register can still take one more beat. Unused
// op codes give a zero result and leave the flags untouched.
module alu_with_condition_flags_core
(
    input  logic          clk,
    input  logic          rst_n,
    alu_cf_req_if.sink    req,
    alu_cf_rsp_if.source  rsp
);
    import alu_cf_pkg::*;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    req_beat_t         s1_beat_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [DATA_W-1:0] result_reg;
    logic              cond_true_reg;
    logic [FLAG_W-1:0] flags_reg;
    logic [FLAG_W-1:0] nzcv_reg;
    logic [FLAG_W-1:0] nzcv_next;

    logic              out_take;
    logic              s1_adv;
    logic              req_fire;
    logic [DATA_W-1:0] alu_result;
    flag_upd_t         flag_upd;
    logic [FLAG_W-1:0] flags_cur;
    logic              cond_hit;

    assign out_take  = ~out_valid_reg | rsp.ready;
    assign s1_adv    = s1_valid_reg & out_take;
    assign req.ready = ~s1_valid_reg | s1_adv;
    assign req_fire  = req.valid & req.ready;

    alu_cf_exec u_exec
    (
        .beat     (s1_beat_reg),
        .result   (alu_result),
        .flag_upd (flag_upd)
    );

    assign flags_cur = flag_upd.flag_we ? flag_upd.nzcv : nzcv_reg;

    alu_cf_cond u_cond
    (
        .condition (s1_beat_reg.condition),
        .flags     (flags_cur),
        .cond_true (cond_hit)
    );

    always_comb
    begin
        s1_valid_next  = req_fire | (s1_valid_reg & ~s1_adv);
        out_valid_next = s1_adv | (out_valid_reg & ~rsp.ready);
        nzcv_next      = s1_adv ? flags_cur : nzcv_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            nzcv_reg      <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            nzcv_reg      <= nzcv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_beat_reg.op         <= req.op;
            s1_beat_reg.operand_a  <= req.operand_a;
            s1_beat_reg.operand_b  <= req.operand_b;
            s1_beat_reg.move_shift <= req.move_shift;
            s1_beat_reg.set_flags  <= req.set_flags;
            s1_beat_reg.condition  <= req.condition;
        end
        if (s1_adv)
        begin
            result_reg    <= alu_result;
            cond_true_reg <= cond_hit;
            flags_reg     <= flags_cur;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.result    = result_reg;
    assign rsp.cond_true = cond_true_reg;
    assign rsp.flags_out = flags_reg;
endmodule

[design/alu_cf_exec.sv]
module alu_cf_exec
(
    input  alu_cf_pkg::req_beat_t         beat,
    output logic [alu_cf_pkg::DATA_W-1:0] result,
    output alu_cf_pkg::flag_upd_t         flag_upd
);
    import alu_cf_pkg::*;

    logic [DATA_W-1:0]  a;
    logic [DATA_W-1:0]  b;
    logic [DATA_W-1:0]  b_eff;
    logic [DATA_W:0]    sum_wide;
    logic [SHAMT_W-1:0] sh;
    logic               is_sub;
    logic               is_arith;
    logic               op_ok;
    logic               carry;
    logic               ovf;

    assign a      = beat.operand_a;
    assign b      = beat.operand_b;
    assign sh     = b[SHAMT_W-1:0];
    assign is_sub = (beat.op == OP_SUB);
    assign b_eff  = is_sub ? ~b : b;

    // one adder for add and subtract, carry in set for subtract
    assign sum_wide = {1'b0, a} + {1'b0, b_eff} + {{DATA_W{1'b0}}, is_sub};

    always_comb
    begin
        result   = '0;
        op_ok    = 1'b1;
        is_arith = 1'b0;
        case (op_t'(beat.op))
            OP_ADD:
            begin
                result   = sum_wide[DATA_W-1:0];
                is_arith = 1'b1;
            end
            OP_SUB:
            begin
                result   = sum_wide[DATA_W-1:0];
                is_arith = 1'b1;
            end
            OP_NOT:    result = ~a;
            OP_OR:     result = a | b;
            OP_XOR:    result = a ^ b;
            OP_AND:    result = a & b;
            OP_MOVK:   result = a | (b << beat.move_shift);
            OP_LSL:    result = a << sh;
            OP_LSR:    result = a >> sh;
            OP_ASR:    result = DATA_W'($signed(a) >>> sh);
            OP_PASS_A: result = a;
            OP_PASS_B: result = b;
            default:
            begin
                result = '0;
                op_ok  = 1'b0;
            end
        endcase
    end

    // carry out of a + ~b + 1 is the no-borrow flag
    assign carry = is_arith & sum_wide[DATA_W];
    assign ovf   = is_arith & (a[DATA_W-1] == b_eff[DATA_W-1])
                 & (sum_wide[DATA_W-1] != a[DATA_W-1]);

    always_comb
    begin
        flag_upd.flag_we        = beat.set_flags & op_ok;
        flag_upd.nzcv           = '0;
        flag_upd.nzcv[FLAG_N]   = result[DATA_W-1];
        flag_upd.nzcv[FLAG_Z]   = (result == '0);
        flag_upd.nzcv[FLAG_C]   = carry;
        flag_upd.nzcv[FLAG_V]   = ovf;
    end
endmodule

[design/alu_cf_cond.sv]
module alu_cf_cond
(
    input  logic [alu_cf_pkg::COND_W-1:0] condition,
    input  logic [alu_cf_pkg::FLAG_W-1:0] flags,
    output logic                          cond_true
);
    import alu_cf_pkg::*;

    logic n;
    logic z;
    logic c;
    logic v;
    logic base;
    logic always_true;

    assign n = flags[FLAG_N];
    assign z = flags[FLAG_Z];
    assign c = flags[FLAG_C];
    assign v = flags[FLAG_V];

    always_comb
    begin
        base        = 1'b0;
        always_true = 1'b0;
        case (cond_t'(condition))
            COND_EQ, COND_NE: base = z;
            COND_CS, COND_CC: base = c;
            COND_MI, COND_PL: base = n;
            COND_VS, COND_VC: base = v;
            COND_HI, COND_LS: base = c & ~z;
            COND_GE, COND_LT: base = (n == v);
            COND_GT, COND_LE: base = (n == v) & ~z;
            COND_AL, COND_NV: always_true = 1'b1;
            default:          always_true = 1'b1;
        endcase
    end

    // odd codes test the inverse, but NV is always true like AL
    assign cond_true = always_true | (base ^ condition[0]);
endmodule

[design/alu_cf_checker.sv]
module alu_cf_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [alu_cf_pkg::DATA_W-1:0] rsp_result,
    input logic [alu_cf_pkg::FLAG_W-1:0] rsp_flags_out
);
    import alu_cf_pkg::*;

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result)
            && $stable(rsp_flags_out))
        else $error("result beat dropped or changed while stalled");

    // a fresh result follows an accepted beat that went unstalled through the input and result registers
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
        else $error("result beat without matching request beat");

    // zero and negative never hold together
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp_flags_out[FLAG_N] && rsp_flags_out[FLAG_Z]))
        else $error("flags show both negative and zero");

    // nothing comes out straight after reset
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !rsp_valid)
        else $error("result beat straight after reset");
endmodule

bind alu_with_condition_flags_core alu_cf_checker u_alu_cf_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_result    (rsp.result),
    .rsp_flags_out (rsp.flags_out)
);

[test/tb.sv]
module tb;
    import alu_cf_pkg::*;

    localparam int PIPE_DEPTH  = 2;
    localparam int CYCLE_LIMIT = 200000;

    localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};
    localparam logic [DATA_W-1:0] SIGN_BIT = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] MAX_POS  = {1'b0, {(DATA_W-1){1'b1}}};

    localparam logic [OP_W-1:0] OP_FIRST_UNUSED = 4'd12;
    localparam logic [OP_W-1:0] OP_LAST_UNUSED  = 4'd15;

    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic              cond_true;
        logic [FLAG_W-1:0] flags;
    } alu_out_t;

    logic clk;
    logic rst_n;

    alu_cf_req_if req ();
    alu_cf_rsp_if rsp ();

    alu_with_condition_flags_core DUT
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    alu_out_t          pending_results[$];
    logic [FLAG_W-1:0] nzcv_model;
    alu_out_t          want;
    bit                idle_on;
    int                errors;
    int                beats_sent;
    int                results_seen;
    int                cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic cond_met(input logic [COND_W-1:0] cc,
                                      input logic [FLAG_W-1:0] f);
        logic base;
        case (cc)
            COND_EQ, COND_NE: base = f[FLAG_Z];
            COND_CS, COND_CC: base = f[FLAG_C];
            COND_MI, COND_PL: base = f[FLAG_N];
            COND_VS, COND_VC: base = f[FLAG_V];
            COND_HI, COND_LS: base = f[FLAG_C] && !f[FLAG_Z];
            COND_GE, COND_LT: base = (f[FLAG_N] == f[FLAG_V]);
            COND_GT, COND_LE: base = (f[FLAG_N] == f[FLAG_V]) && !f[FLAG_Z];
            default: return 1'b1;
        endcase
        // odd codes are the inverse of their even partner
        return cc[0] ? !base : base;
    endfunction

    function automatic alu_out_t alu_predict(input req_beat_t beat);
        alu_out_t            o;
        logic [DATA_W-1:0]   a;
        logic [DATA_W-1:0]   b;
        logic [SHAMT_W-1:0]  sh;
        logic [DATA_W-1:0]   res;
        logic                c;
        logic                v;
        logic                known;
        a     = beat.operand_a;
        b     = beat.operand_b;
        sh    = b[SHAMT_W-1:0];
        c     = 1'b0;
        v     = 1'b0;
        known = 1'b1;
        case (beat.op)
            OP_ADD:
            begin
                {c, res} = {1'b0, a} + {1'b0, b};
                v = ((a ^ res) & (b ^ res) & SIGN_BIT) != '0;
            end
            OP_SUB:
            begin
                res = a - b;
                c   = (a >= b);
                v   = ((a ^ b) & (a ^ res) & SIGN_BIT) != '0;
            end
            OP_NOT:    res = ~a;
            OP_OR:     res = a | b;
            OP_XOR:    res = a ^ b;
            OP_AND:    res = a & b;
            OP_MOVK:   res = a | (b << beat.move_shift);
            OP_LSL:    res = a << sh;
            OP_LSR:    res = a >> sh;
            OP_ASR:    res = $unsigned($signed(a) >>> sh);
            OP_PASS_A: res = a;
            OP_PASS_B: res = b;
            default:
            begin
                res   = '0;
                known = 1'b0;
            end
        endcase
        if (beat.set_flags && known)
        begin
            nzcv_model[FLAG_N] = res[DATA_W-1];
            nzcv_model[FLAG_Z] = (res == '0);
            nzcv_model[FLAG_C] = c;
            nzcv_model[FLAG_V] = v;
        end
        o.result    = res;
        o.cond_true = cond_met(beat.condition, nzcv_model);
        o.flags     = nzcv_model;
        return o;
    endfunction

    function automatic req_beat_t mk(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] a,
                                     input logic [DATA_W-1:0] b,
                                     input logic [SHAMT_W-1:0] msh, input logic setf);
        req_beat_t beat;
        beat.op         = op;
        beat.operand_a  = a;
        beat.operand_b  = b;
        beat.move_shift = msh;
        beat.set_flags  = setf;
        beat.condition  = COND_AL;
        return beat;
    endfunction

    function automatic logic [DATA_W-1:0] rand_operand();
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return ALL_ONES;
            2:       return SIGN_BIT;
            3:       return MAX_POS;
            4:       return DATA_W'($urandom_range(0, 255));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic req_beat_t rand_beat();
        req_beat_t beat;
        if ($urandom_range(0, 19) == 0)
            beat.op = OP_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
        else
            beat.op = OP_W'($urandom_range(OP_ADD, OP_PASS_B));
        beat.operand_a = rand_operand();
        // equal operands give zero results on sub and xor
        if ($urandom_range(0, 5) == 0)
            beat.operand_b = beat.operand_a;
        else
            beat.operand_b = rand_operand();
        beat.move_shift = SHAMT_W'($urandom_range(0, 63));
        beat.set_flags  = ($urandom_range(0, 3) != 0);
        beat.condition  = COND_W'($urandom_range(COND_EQ, COND_NV));
        return beat;
    endfunction

    task automatic send_beat(input req_beat_t beat);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            req.valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        req.op         = beat.op;
        req.operand_a  = beat.operand_a;
        req.operand_b  = beat.operand_b;
        req.move_shift = beat.move_shift;
        req.set_flags  = beat.set_flags;
        req.condition  = beat.condition;
        req.valid      = 1'b1;
        do
            @(posedge clk);
        while (!req.ready);
        beats_sent++;
    endtask

    task automatic idle_req();
        @(negedge clk);
        req.valid = 1'b0;
    endtask

    task automatic wait_quiet();
        idle_req();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_corner_values();
        req_beat_t corner[$];
        req_beat_t beat;
        corner.push_back(mk(OP_ADD, ALL_ONES, 64'd1, 6'd0, 1'b1));
        corner.push_back(mk(OP_ADD, MAX_POS, 64'd1, 6'd0, 1'b1));
        corner.push_back(mk(OP_ADD, '0, '0, 6'd0, 1'b1));
        corner.push_back(mk(OP_SUB, 64'd5, 64'd5, 6'd0, 1'b1));
        corner.push_back(mk(OP_SUB, '0, 64'd1, 6'd0, 1'b1));
        corner.push_back(mk(OP_SUB, SIGN_BIT, 64'd1, 6'd0, 1'b1));
        corner.push_back(mk(OP_SUB, MAX_POS, ALL_ONES, 6'd0, 1'b1));
        corner.push_back(mk(OP_NOT, ALL_ONES, '0, 6'd0, 1'b1));
        corner.push_back(mk(OP_NOT, '0, '0, 6'd0, 1'b1));
        corner.push_back(mk(OP_OR, SIGN_BIT, 64'h1234, 6'd0, 1'b1));
        corner.push_back(mk(OP_XOR, ALL_ONES, ALL_ONES, 6'd0, 1'b1));
        corner.push_back(mk(OP_AND, 64'hF0F0_F0F0_F0F0_F0F0, 64'h0FF0_0FF0_0FF0_0FF0,
                            6'd0, 1'b1));
        corner.push_back(mk(OP_MOVK, 64'h1, 64'hFFFF, 6'd48, 1'b1));
        corner.push_back(mk(OP_MOVK, '0, 64'h1, 6'd63, 1'b1));
        corner.push_back(mk(OP_MOVK, SIGN_BIT, ALL_ONES, 6'd0, 1'b1));
        corner.push_back(mk(OP_LSL, 64'h3, 64'hFFFF_0000_0000_0040, 6'd0, 1'b1));
        corner.push_back(mk(OP_LSL, 64'h3, 64'd63, 6'd0, 1'b1));
        corner.push_back(mk(OP_LSR, SIGN_BIT, ALL_ONES, 6'd0, 1'b1));
        corner.push_back(mk(OP_ASR, SIGN_BIT, 64'd63, 6'd0, 1'b1));
        corner.push_back(mk(OP_ASR, ALL_ONES, 64'h100, 6'd0, 1'b1));
        corner.push_back(mk(OP_ASR, MAX_POS, 64'd1, 6'd0, 1'b1));
        corner.push_back(mk(OP_PASS_A, SIGN_BIT, '0, 6'd0, 1'b1));
        corner.push_back(mk(OP_PASS_B, ALL_ONES, '0, 6'd0, 1'b1));
        corner.push_back(mk(OP_ADD, ALL_ONES, ALL_ONES, 6'd0, 1'b0));
        foreach (corner[i])
        begin
            beat           = corner[i];
            beat.condition = COND_W'(i);
            send_beat(beat);
        end
        idle_req();
    endtask

    // unused codes must hold the flags even with the set enable high
    task automatic test_unused_ops();
        req_beat_t beat;
        for (int code = OP_FIRST_UNUSED; code <= OP_LAST_UNUSED; code++)
        begin
            send_beat(mk(OP_SUB, rand_operand(), rand_operand(), 6'd0, 1'b1));
            beat           = mk(OP_W'(code), rand_operand(), rand_operand(),
                                SHAMT_W'($urandom_range(0, 63)), 1'b1);
            beat.condition = COND_W'($urandom_range(COND_EQ, COND_NV));
            send_beat(beat);
        end
        idle_req();
    endtask

    task automatic test_random_mix(input int count);
        repeat (count) send_beat(rand_beat());
        idle_req();
    endtask

    task automatic test_quiet_pause();
        repeat (10) send_beat(rand_beat());
        wait_quiet();
        repeat (10) send_beat(rand_beat());
        idle_req();
    endtask

    task automatic test_back_to_back(input int count);
        idle_on = 1'b0;
        repeat (count) send_beat(rand_beat());
        idle_req();
    endtask

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 4) == 0)
            begin
                rsp.ready = 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge clk);
            end
            rsp.ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && req.valid && req.ready)
            pending_results.push_back(alu_predict({req.op, req.operand_a, req.operand_b,
                                                   req.move_shift, req.set_flags,
                                                   req.condition}));
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result beat with nothing pending: result %h", $time,
                         rsp.result);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp.result !== want.result)
                begin
                    $display("%0t: result expected %h got %h", $time, want.result,
                             rsp.result);
                    errors++;
                end
                if (rsp.cond_true !== want.cond_true)
                begin
                    $display("%0t: cond_true expected %b got %b", $time, want.cond_true,
                             rsp.cond_true);
                    errors++;
                end
                if (rsp.flags_out !== want.flags)
                begin
                    $display("%0t: flags_out expected %b got %b", $time, want.flags,
                             rsp.flags_out);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timed out with %0d results pending", $time,
                     pending_results.size());
            $display("tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        idle_on        = 1'b1;
        nzcv_model     = '0;
        errors         = 0;
        beats_sent     = 0;
        results_seen   = 0;
        cycle_count    = 0;
        req.valid      = 1'b0;
        req.op         = OP_ADD;
        req.operand_a  = '0;
        req.operand_b  = '0;
        req.move_shift = '0;
        req.set_flags  = 1'b0;
        req.condition  = COND_AL;
        rsp.ready      = 1'b1;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_corner_values();
        test_unused_ops();
        test_random_mix(400);
        test_quiet_pause();
        test_random_mix(250);
        test_back_to_back(250);

        wait_quiet();
        repeat (PIPE_DEPTH + 8) @(posedge clk);

        $display("tb: %0d beats sent, %0d results checked, %0d mismatches", beats_sent,
                 results_seen, errors);
        $display("tb: covered all ops, unused codes, all conditions, idle and stall bursts");
        if (errors == 0 && pending_results.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
